/* rtl/isfd_pkg.sv */
// ----------------------------------------------------------------------------
// isfd_pkg - shared types and constants for the IMU serial frame decoder
// Frame layout, register indexes, result kinds and fixed-point scale factors.
// ----------------------------------------------------------------------------
package isfd_pkg;

  localparam int FRAME_LEN = 11;
  // data cells hold every byte except the trailing sum byte
  localparam int CELLS     = FRAME_LEN - 1;
  localparam int CNT_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] START_RST = 8'd85;
  localparam logic [7:0] ACCEL_RST = 8'd81;
  localparam logic [7:0] GYRO_RST  = 8'd82;
  localparam logic [7:0] ANGLE_RST = 8'd83;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_ACCEL = 2'd1,
    REG_GYRO  = 2'd2,
    REG_ANGLE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  // rate: raw * 125 / 128, angle: raw * 45 / 128
  localparam logic signed [23:0] GYRO_MUL  = 24'sd125;
  localparam logic signed [23:0] ANGLE_MUL = 24'sd45;
  localparam int                 AXIS_SHIFT = 7;

  // temperature: floor((raw*64 + 85*24674) / 85) - 24674 + 9280
  localparam int          TEMP_P_W    = 23;
  localparam logic [23:0] TEMP_BIAS   = 24'd2097290;
  localparam int          TEMP_SHIFT  = 31;
  // ceil(2^31 / 85); error term 42 * p stays below 2^31 for p < 2^23
  localparam logic [24:0] TEMP_RECIP  = 25'd25264514;
  localparam logic [16:0] TEMP_OFFSET = 17'd15394;

  typedef struct packed {
    kind_t                 kind;
    logic signed [15:0]    x;
    logic signed [15:0]    y;
    logic signed [15:0]    z;
    logic [TEMP_P_W-1:0]   temp_p;
  } raw_frame_t;

endpackage

/* rtl/isfd_cell.sv */
// ----------------------------------------------------------------------------
// isfd_cell - one byte cell of the frame shift chain
// Loads the byte from its upstream neighbor whenever the chain advances.
// ----------------------------------------------------------------------------
module isfd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

/* rtl/isfd_scale.sv */
// ----------------------------------------------------------------------------
// isfd_scale - fixed-point scaling and result register
// Scales the three axis words per frame kind, converts temperature through a
// reciprocal multiply, and holds the result until the downstream transfer.
// ----------------------------------------------------------------------------
module isfd_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      frame_valid,
  input  isfd_pkg::raw_frame_t      frame,
  output logic                      frame_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic signed [15:0]        axis_x,
  output logic signed [15:0]        axis_y,
  output logic signed [15:0]        axis_z,
  output logic signed [16:0]        temperature
);

  logic signed [23:0] mul;
  logic signed [15:0] x_next;
  logic signed [15:0] y_next;
  logic signed [15:0] z_next;
  logic [47:0]        t_prod;
  logic [16:0]        t_next;

  function automatic logic signed [15:0] scale_axis(input logic signed [15:0] raw,
                                                    input logic signed [23:0] m,
                                                    input logic               pass);
    logic signed [23:0] wide;
    logic signed [23:0] prod;
    wide = 24'(raw);
    prod = wide * m;
    // arithmetic shift by AXIS_SHIFT; the scaled value fits 16 bits
    scale_axis = pass ? raw : prod[isfd_pkg::AXIS_SHIFT +: 16];
  endfunction

  assign frame_ready = !out_valid || out_ready;

  always_comb begin
    mul    = (frame.kind == isfd_pkg::KIND_GYRO) ? isfd_pkg::GYRO_MUL
                                                 : isfd_pkg::ANGLE_MUL;
    x_next = scale_axis(frame.x, mul, frame.kind == isfd_pkg::KIND_ACCEL);
    y_next = scale_axis(frame.y, mul, frame.kind == isfd_pkg::KIND_ACCEL);
    z_next = scale_axis(frame.z, mul, frame.kind == isfd_pkg::KIND_ACCEL);
    t_prod = 48'(frame.temp_p) * 48'(isfd_pkg::TEMP_RECIP);
    t_next = t_prod[isfd_pkg::TEMP_SHIFT +: 17] - isfd_pkg::TEMP_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_ready) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ready && frame_valid) begin
      kind        <= frame.kind;
      axis_x      <= x_next;
      axis_y      <= y_next;
      axis_z      <= z_next;
      temperature <= t_next;
    end
  end

endmodule

/* rtl/imu_serial_frame_decoder.sv */
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder - 11-byte IMU serial frame parser
// Hunts for the start byte, collects a frame in a byte-cell chain, checks the
// 8-bit sum and type, and emits scaled fixed-point X, Y, Z and temperature.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle unless stalled. Bytes shift through a chain
// of ten byte cells; the eleventh (sum) byte is compared with the running sum
// on arrival, and a good frame of a known type is latched into a decode stage.
// The scale stage and result register follow; the decode stage registers the
// frame and the result register holds the scaled result. Input stalls only
// while a decoded frame waits behind an untaken result.
// Bad, unknown or misheaded frames are dropped without any result.
module imu_serial_frame_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] axis_x,
  output logic signed [15:0] axis_y,
  output logic signed [15:0] axis_z,
  output logic signed [16:0] temperature,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int CELLS = isfd_pkg::CELLS;
  localparam int CNT_W = isfd_pkg::CNT_W;

  logic [7:0] start_byte;
  logic [7:0] accel_code;
  logic [7:0] gyro_code;
  logic [7:0] angle_code;

  logic             hunting;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       running_sum;
  logic [7:0]       cell_q [CELLS];

  logic in_fire;
  logic shift_en;
  logic last_byte;
  logic frame_ok;

  isfd_pkg::kind_t      kind_dec;
  logic                 type_known;
  logic signed [15:0]   temp_raw;
  logic [23:0]          temp_sum;
  isfd_pkg::raw_frame_t frame_next;
  isfd_pkg::raw_frame_t frame;
  logic                 frame_valid;
  logic                 frame_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= isfd_pkg::START_RST;
      accel_code <= isfd_pkg::ACCEL_RST;
      gyro_code  <= isfd_pkg::GYRO_RST;
      angle_code <= isfd_pkg::ANGLE_RST;
    end else if (cfg_valid) begin
      unique case (isfd_pkg::cfg_reg_t'(cfg_index))
        isfd_pkg::REG_START: start_byte <= cfg_data;
        isfd_pkg::REG_ACCEL: accel_code <= cfg_data;
        isfd_pkg::REG_GYRO:  gyro_code  <= cfg_data;
        isfd_pkg::REG_ANGLE: angle_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = !frame_valid || frame_ready;
  assign in_fire   = in_valid && in_ready;
  assign last_byte = in_fire && !hunting && (byte_count == CNT_W'(CELLS));
  assign shift_en  = in_fire && (!hunting || rx_byte == start_byte) &&
                     (byte_count != CNT_W'(CELLS));

  // cell 0 takes the newest byte; frame byte i sits in cell CELLS-1-i
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    isfd_cell u_cell (
      .clk   (clk),
      .shift (shift_en),
      .d     (j == 0 ? rx_byte : cell_q[(j == 0) ? 0 : j - 1]),
      .q     (cell_q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting     <= 1'b1;
      byte_count  <= '0;
      running_sum <= '0;
    end else if (shift_en) begin
      hunting     <= 1'b0;
      byte_count  <= byte_count + 1'b1;
      running_sum <= running_sum + rx_byte;
    end else if (last_byte) begin
      hunting     <= 1'b1;
      byte_count  <= '0;
      running_sum <= '0;
    end
  end

  always_comb begin
    type_known = 1'b1;
    priority if (cell_q[CELLS-2] == accel_code) begin
      kind_dec = isfd_pkg::KIND_ACCEL;
    end else if (cell_q[CELLS-2] == gyro_code) begin
      kind_dec = isfd_pkg::KIND_GYRO;
    end else if (cell_q[CELLS-2] == angle_code) begin
      kind_dec = isfd_pkg::KIND_ANGLE;
    end else begin
      kind_dec   = isfd_pkg::KIND_ACCEL;
      type_known = 1'b0;
    end
    frame_ok = last_byte && type_known && (cell_q[CELLS-1] == start_byte) &&
               (rx_byte == running_sum);

    temp_raw = {cell_q[0], cell_q[1]};
    // raw * 64 plus bias keeps the dividend positive
    temp_sum = {{2{temp_raw[15]}}, temp_raw, 6'b0} + isfd_pkg::TEMP_BIAS;

    frame_next.kind   = kind_dec;
    frame_next.x      = {cell_q[6], cell_q[7]};
    frame_next.y      = {cell_q[4], cell_q[5]};
    frame_next.z      = {cell_q[2], cell_q[3]};
    frame_next.temp_p = temp_sum[isfd_pkg::TEMP_P_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_ok) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ok) begin
      frame <= frame_next;
    end
  end

  isfd_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .temperature (temperature)
  );

`ifndef SYNTH
  a_hunt_empty: assert property (@(posedge clk) disable iff (rst)
    hunting |-> (byte_count == '0 && running_sum == '0))
    else $error("hunting with a partial frame");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(CELLS))
    else $error("byte count past frame length");

  a_decode_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame))
    else $error("decoded frame lost while stalled");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    last_byte |=> hunting)
    else $error("sum byte did not end the frame");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.kind == isfd_pkg::KIND_ACCEL ||
                     frame.kind == isfd_pkg::KIND_GYRO ||
                     frame.kind == isfd_pkg::KIND_ANGLE))
    else $error("decoded frame with unknown kind");
`endif

endmodule

/* bench/isfd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_checker - scoreboard for the IMU serial frame decoder
// Follows every byte, register write and result transfer on the decoder's
// channels, decodes frames on its own and compares each result field by field.
// ----------------------------------------------------------------------------
module isfd_checker
  import isfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         kind,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [16:0] temperature,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    kind_t              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [16:0] temp;
  } reading_t;

  reading_t readings_due[$];

  logic [7:0] hdr_byte;
  logic [7:0] accel_type;
  logic [7:0] gyro_type;
  logic [7:0] angle_type;

  logic       seeking;
  logic [3:0] fill;
  logic [7:0] held [CELLS];
  logic [7:0] sum_acc;

  function automatic logic signed [15:0] word_from(int lo);
    return {held[lo+1], held[lo]};
  endfunction

  // floor(raw * mul / 128); arithmetic shift rounds toward minus infinity
  function automatic logic signed [15:0] rescale(logic signed [15:0] raw, int mul);
    int p;
    p = raw * mul;
    return 16'(p >>> 7);
  endfunction

  function automatic logic signed [16:0] to_celsius(logic signed [15:0] raw);
    int p;
    int q;
    p = raw * 64;
    q = p / 85;
    // division truncates toward zero, floor needs one less for negative remainders
    if ((p % 85) != 0 && p < 0) q = q - 1;
    return 17'(q + 9280);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    reading_t   r;
    logic [7:0] sum_now;
    logic [7:0] typ;
    if (seeking && b != hdr_byte) return;
    seeking = 1'b0;
    if (fill < 4'(CELLS)) begin
      held[fill] = b;
      sum_acc    = sum_acc + b;
      fill       = fill + 4'd1;
      return;
    end
    // sum byte closes the frame whatever its fate
    sum_now = sum_acc;
    seeking = 1'b1;
    fill    = '0;
    sum_acc = '0;
    if (held[0] != hdr_byte || b != sum_now) return;
    typ = held[1];
    r.x = word_from(2);
    r.y = word_from(4);
    r.z = word_from(6);
    if (typ == accel_type) begin
      r.kind = KIND_ACCEL;
    end else if (typ == gyro_type) begin
      r.kind = KIND_GYRO;
      r.x = rescale(r.x, 125);
      r.y = rescale(r.y, 125);
      r.z = rescale(r.z, 125);
    end else if (typ == angle_type) begin
      r.kind = KIND_ANGLE;
      r.x = rescale(r.x, 45);
      r.y = rescale(r.y, 45);
      r.z = rescale(r.z, 45);
    end else begin
      return;
    end
    r.temp = to_celsius(word_from(8));
    readings_due.push_back(r);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      hdr_byte   = START_RST;
      accel_type = ACCEL_RST;
      gyro_type  = GYRO_RST;
      angle_type = ANGLE_RST;
      seeking    = 1'b1;
      fill       = '0;
      sum_acc    = '0;
      readings_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          flag_mismatch("result transfer with no frame outstanding");
        end else begin
          want = readings_due.pop_front();
          if (kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
          if (axis_x !== want.x)
            flag_mismatch($sformatf("axis_x %0d, predicted %0d", axis_x, want.x));
          if (axis_y !== want.y)
            flag_mismatch($sformatf("axis_y %0d, predicted %0d", axis_y, want.y));
          if (axis_z !== want.z)
            flag_mismatch($sformatf("axis_z %0d, predicted %0d", axis_z, want.z));
          if (temperature !== want.temp)
            flag_mismatch($sformatf("temperature %0d, predicted %0d",
                                    temperature, want.temp));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START: hdr_byte   = cfg_data;
          REG_ACCEL: accel_type = cfg_data;
          REG_GYRO:  gyro_type  = cfg_data;
          REG_ANGLE: angle_type = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(rx_byte);
    end
    pending <= readings_due.size();
  end

  always @(posedge clk) begin
    if (!rst && pending != 0 && $isunknown(out_valid))
      flag_mismatch("out_valid unknown while results are outstanding");
  end

endmodule

/* bench/tb_imu_serial_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_serial_frame_decoder - stimulus and verdict for the frame decoder
// Sends directed and random byte streams (good, corrupt, cut and noisy frames)
// under several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_imu_serial_frame_decoder;
  import isfd_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 3000;

  typedef enum { FLAW_NONE, FLAW_SUM, FLAW_CUT, FLAW_SPLIT } flaw_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [16:0] temperature;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = REG_START;
  logic [7:0]         cfg_data = '0;

  int fail_count;
  int pending;

  logic [7:0] cur_start = START_RST;
  logic [7:0] cur_accel = ACCEL_RST;
  logic [7:0] cur_gyro  = GYRO_RST;
  logic [7:0] cur_angle = ANGLE_RST;

  bit tx_gaps      = 1'b1;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  bit hold_served  = 1'b0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  imu_serial_frame_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .temperature (temperature),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  isfd_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .temperature (temperature),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // end the run if no channel moves a transfer for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    repeat (3) @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold the byte stream until every result is out and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [7:0] s, a, g, n);
    logic [7:0] vals [4];
    vals = '{s, a, g, n};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_start = s;
    cur_accel = a;
    cur_gyro  = g;
    cur_angle = n;
  endtask

  // ten non-start bytes finish any open frame and leave the decoder hunting
  task automatic resync();
    logic [7:0] b;
    repeat (CELLS) begin
      do b = 8'($urandom); while (b == cur_start);
      push_byte(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] typ, input logic [15:0] wx, wy, wz, wt,
                            input flaw_t flaw);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] sum;
    int         stop;
    fr[0] = cur_start;
    fr[1] = typ;
    fr[2] = wx[7:0];
    fr[3] = wx[15:8];
    fr[4] = wy[7:0];
    fr[5] = wy[15:8];
    fr[6] = wz[7:0];
    fr[7] = wz[15:8];
    fr[8] = wt[7:0];
    fr[9] = wt[15:8];
    sum = '0;
    for (int i = 0; i < CELLS; i++) sum += fr[i];
    fr[CELLS] = (flaw == FLAW_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
    stop = (flaw == FLAW_CUT) ? $urandom_range(2, CELLS) : FRAME_LEN;
    for (int i = 0; i < stop; i++) begin
      if (flaw == FLAW_SPLIT && i == 5) begin
        // move the header register under the open frame
        drain();
        write_all(~cur_start, cur_accel, cur_gyro, cur_angle);
      end
      push_byte(fr[i]);
    end
    if (flaw == FLAW_CUT) resync();
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return {cur_start, cur_start};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] known_type();
    case ($urandom_range(0, 2))
      0:       return cur_accel;
      1:       return cur_gyro;
      default: return cur_angle;
    endcase
  endfunction

  function automatic logic [7:0] foreign_type();
    logic [7:0] t;
    do t = 8'($urandom); while (t == cur_accel || t == cur_gyro || t == cur_angle);
    return t;
  endfunction

  task automatic random_phase(input int target);
    int goal;
    int pick;
    goal = items_sent + target;
    while (items_sent < goal) begin
      tx_gaps = !calm && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(known_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                   FLAW_NONE);
      end else if (pick < 78) begin
        send_frame(known_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                   FLAW_SUM);
      end else if (pick < 84) begin
        send_frame(foreign_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                   FLAW_NONE);
      end else if (pick < 90) begin
        send_frame(known_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                   FLAW_CUT);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        resync();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of every kind, then the drop cases
    send_frame(cur_accel, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, FLAW_NONE);
    send_frame(cur_gyro,  16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, FLAW_NONE);
    send_frame(cur_angle, 16'h0001, 16'hFFFF, 16'hFF80, 16'h0000, FLAW_NONE);
    send_frame(cur_accel, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, FLAW_SUM);
    send_frame(foreign_type(), 16'h0100, 16'h0200, 16'h0300, 16'h0400, FLAW_NONE);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(cur_gyro, {cur_start, cur_start}, {cur_start, cur_start},
               16'h00FF, {cur_start, cur_start}, FLAW_NONE);
    send_frame(cur_angle, 16'h4000, 16'hC000, 16'h0080, 16'h0055, FLAW_CUT);
    send_frame(cur_accel, 16'h0010, 16'h0020, 16'h0030, 16'h0040, FLAW_SPLIT);
    send_frame(cur_accel, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, FLAW_NONE);

    // shared type codes: accel wins over all, gyro over angle
    drain();
    write_all(cur_start, 8'h40, 8'h40, 8'h40);
    send_frame(8'h40, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, FLAW_NONE);
    drain();
    write_all(cur_start, 8'h41, 8'h42, 8'h42);
    send_frame(8'h42, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, FLAW_NONE);
    drain();

    // random phases; the first one carries the long result hold-off
    write_all(8'h00, 8'hFF, 8'h00, 8'h80);
    hold_request = 1'b1;
    random_phase(140);
    drain();
    write_all(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(140);
    drain();
    write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(140);
    drain();
    calm    = 1'b1;
    tx_gaps = 1'b0;
    write_all(START_RST, ACCEL_RST, GYRO_RST, ANGLE_RST);
    random_phase(140);
    drain();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/isfd_pkg.sv
rtl/isfd_cell.sv
rtl/isfd_scale.sv
rtl/imu_serial_frame_decoder.sv
bench/isfd_checker.sv
bench/tb_imu_serial_frame_decoder.sv
